// ===== hw/rtl/bsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounding sphere merge package
// Shared widths, the selection code and the payload records that travel
// alongside the square root and divider cell chains.
// ----------------------------------------------------------------------------
package bsm_pkg;

  localparam int SqrtSteps = 33;
  localparam int DivSteps  = 32;
  localparam logic [30:0] RadiusMax = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    SEL_FIRST,
    SEL_SECOND,
    SEL_MERGE
  } sel_t;

  typedef struct packed {
    logic [2:0][31:0] c1;
    logic [2:0][31:0] c2;
    logic [30:0]      r1;
    logic [30:0]      r2;
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
  } head_t;

  typedef struct packed {
    logic [2:0][31:0] c1;
    logic [2:0][31:0] c2;
    logic [2:0]       neg;
    sel_t             sel;
    logic [30:0]      radius;
  } tail_t;

endpackage

// ===== hw/rtl/bsm_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root cell
// One digit of the restoring square root; the row of cells retires one bit
// of the distance per stage.
// ----------------------------------------------------------------------------
module bsm_sqrt_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [65:0]   in_s,
  input  logic [33:0]   in_rem,
  input  logic [32:0]   in_root,
  input  bsm_pkg::head_t in_head,
  output logic          valid,
  output logic [65:0]   s,
  output logic [33:0]   rem,
  output logic [32:0]   root,
  output bsm_pkg::head_t head
);
  import bsm_pkg::*;

  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;

  assign rem_sh = {in_rem, in_s[65:64]};
  assign trial  = {1'b0, in_root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s    <= {in_s[63:0], 2'b00};
    rem  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
    root <= {in_root[31:0], ge};
    head <= in_head;
  end

endmodule

// ===== hw/rtl/bsm_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step for each of the three axes against the shared
// distance; the row of cells retires one quotient bit per stage.
// ----------------------------------------------------------------------------
module bsm_div_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [32:0]      in_d,
  input  logic [2:0][32:0] in_rem,
  input  logic [2:0][31:0] in_num,
  input  logic [2:0][31:0] in_q,
  input  bsm_pkg::tail_t   in_tail,
  output logic             valid,
  output logic [32:0]      d,
  output logic [2:0][32:0] rem,
  output logic [2:0][31:0] num,
  output logic [2:0][31:0] q,
  output bsm_pkg::tail_t   tail
);
  import bsm_pkg::*;

  logic [2:0][33:0] t;
  logic [2:0]       ge;
  logic [2:0][32:0] rem_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t[i]        = {in_rem[i], in_num[i][31]};
      ge[i]       = t[i] >= {1'b0, in_d};
      rem_next[i] = ge[i] ? 33'(t[i] - {1'b0, in_d}) : t[i][32:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    d    <= in_d;
    tail <= in_tail;
    for (int i = 0; i < 3; i++) begin
      rem[i] <= rem_next[i];
      num[i] <= {in_num[i][30:0], 1'b0};
      q[i]   <= {in_q[i][30:0], ge[i]};
    end
  end

endmodule

// ===== hw/rtl/bounding_sphere_merge_top.sv =====
// ----------------------------------------------------------------------------
// Bounding sphere merge
// Returns the smallest sphere enclosing two input spheres in Q16.16.
// ----------------------------------------------------------------------------
// An item is taken at a rising edge with start high; busy stays low, so a
// new item may enter in every cycle and one item per cycle is sustained.
// Each item gives exactly one result, shown on the merged_* ports with done
// high. The path is the row of 33 square root cells, one distance bit each,
// and the row of 32 divider cells, one quotient bit each, plus six stages
// for the offsets, squares, sum, containment decision, product and output.
// Results leave in the order items arrived. The receiver cannot stall, so
// nothing is held back. Reset clears all valid flags and drops items in
// flight; it needs no clearing pass.
// ----------------------------------------------------------------------------
module bounding_sphere_merge_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] first_center_x,
  input  logic signed [31:0] first_center_y,
  input  logic signed [31:0] first_center_z,
  input  logic [30:0]        first_radius,
  input  logic signed [31:0] second_center_x,
  input  logic signed [31:0] second_center_y,
  input  logic signed [31:0] second_center_z,
  input  logic [30:0]        second_radius,
  output logic               done,
  output logic signed [31:0] merged_center_x,
  output logic signed [31:0] merged_center_y,
  output logic signed [31:0] merged_center_z,
  output logic [30:0]        merged_radius
);
  import bsm_pkg::*;

  logic [2:0][31:0] in_c1;
  logic [2:0][31:0] in_c2;
  logic [2:0][32:0] in_off;
  head_t            in_head;

  logic             v1, v2, v3;
  head_t            h1, h2, h3;
  logic [2:0][63:0] sq;
  logic [65:0]      sum_sq;

  logic             sv   [0:SqrtSteps];
  logic [65:0]      ss   [0:SqrtSteps];
  logic [33:0]      srem [0:SqrtSteps];
  logic [32:0]      sroot[0:SqrtSteps];
  head_t            shd  [0:SqrtSteps];

  logic [30:0]      dr1, dr2;
  logic [33:0]      sum_d2;
  logic [33:0]      sum_d1;
  logic [34:0]      sum_all;
  logic [33:0]      newr;
  sel_t             sel_next;

  logic             dec_valid;
  logic [32:0]      dec_d;
  logic [32:0]      dec_k;
  logic [2:0][31:0] dec_mag;
  tail_t            dec_tail;

  logic             mul_valid;
  logic [32:0]      mul_d;
  logic [2:0][64:0] prod;
  tail_t            mul_tail;

  logic             dv   [0:DivSteps];
  logic [32:0]      dd   [0:DivSteps];
  logic [2:0][32:0] drem [0:DivSteps];
  logic [2:0][31:0] dnum [0:DivSteps];
  logic [2:0][31:0] dq   [0:DivSteps];
  tail_t            dtl  [0:DivSteps];

  tail_t            fin;
  logic [2:0][31:0] res;

  assign busy = 1'b0;

  assign in_c1 = {first_center_z, first_center_y, first_center_x};
  assign in_c2 = {second_center_z, second_center_y, second_center_x};

  always_comb begin
    in_head.c1 = in_c1;
    in_head.c2 = in_c2;
    in_head.r1 = first_radius;
    in_head.r2 = second_radius;
    for (int i = 0; i < 3; i++) begin
      in_off[i]      = 33'($signed({in_c2[i][31], in_c2[i]}) - $signed({in_c1[i][31], in_c1[i]}));
      in_head.neg[i] = in_off[i][32];
      in_head.mag[i] = in_off[i][32] ? 32'(-in_off[i]) : in_off[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    h1 <= in_head;
    h2 <= h1;
    h3 <= h2;
    for (int i = 0; i < 3; i++) begin
      sq[i] <= h1.mag[i] * h1.mag[i];
    end
    sum_sq <= 66'(sq[0]) + 66'(sq[1]) + 66'(sq[2]);
  end

  assign sv[0]    = v3;
  assign ss[0]    = sum_sq;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign shd[0]   = h3;

  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
    bsm_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (sv[g]),
      .in_s     (ss[g]),
      .in_rem   (srem[g]),
      .in_root  (sroot[g]),
      .in_head  (shd[g]),
      .valid    (sv[g+1]),
      .s        (ss[g+1]),
      .rem      (srem[g+1]),
      .root     (sroot[g+1]),
      .head     (shd[g+1])
    );
  end

  always_comb begin
    dr1     = shd[SqrtSteps].r1;
    dr2     = shd[SqrtSteps].r2;
    sum_d2  = 34'(sroot[SqrtSteps]) + 34'(dr2);
    sum_d1  = 34'(sroot[SqrtSteps]) + 34'(dr1);
    sum_all = 35'(sum_d2) + 35'(dr1);
    newr    = sum_all[34:1];
    if (34'(dr1) >= sum_d2) begin
      sel_next = SEL_FIRST;
    end else if (34'(dr2) >= sum_d1) begin
      sel_next = SEL_SECOND;
    end else begin
      sel_next = SEL_MERGE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
      mul_valid <= 1'b0;
    end else begin
      dec_valid <= sv[SqrtSteps];
      mul_valid <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    dec_d        <= sroot[SqrtSteps];
    dec_k        <= 33'(newr - 34'(dr1));
    dec_mag      <= shd[SqrtSteps].mag;
    dec_tail.c1  <= shd[SqrtSteps].c1;
    dec_tail.c2  <= shd[SqrtSteps].c2;
    dec_tail.neg <= shd[SqrtSteps].neg;
    dec_tail.sel <= sel_next;
    case (sel_next)
      SEL_FIRST:  dec_tail.radius <= dr1;
      SEL_SECOND: dec_tail.radius <= dr2;
      default:    dec_tail.radius <= (newr > 34'(RadiusMax)) ? RadiusMax : newr[30:0];
    endcase

    mul_d    <= dec_d;
    mul_tail <= dec_tail;
    for (int i = 0; i < 3; i++) begin
      prod[i] <= 65'(dec_mag[i]) * 65'(dec_k);
    end
  end

  assign dv[0] = mul_valid;
  assign dd[0] = mul_d;
  assign dtl[0] = mul_tail;
  assign dq[0]  = '0;
  for (genvar a = 0; a < 3; a++) begin : g_lane
    assign drem[0][a] = prod[a][64:32];
    assign dnum[0][a] = prod[a][31:0];
  end

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    bsm_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (dv[g]),
      .in_d     (dd[g]),
      .in_rem   (drem[g]),
      .in_num   (dnum[g]),
      .in_q     (dq[g]),
      .in_tail  (dtl[g]),
      .valid    (dv[g+1]),
      .d        (dd[g+1]),
      .rem      (drem[g+1]),
      .num      (dnum[g+1]),
      .q        (dq[g+1]),
      .tail     (dtl[g+1])
    );
  end

  assign fin = dtl[DivSteps];

  always_comb begin
    logic signed [33:0] shift;
    logic signed [33:0] pos;
    for (int i = 0; i < 3; i++) begin
      shift = fin.neg[i] ? -$signed({2'b00, dq[DivSteps][i]})
                         : $signed({2'b00, dq[DivSteps][i]});
      pos   = $signed({{2{fin.c1[i][31]}}, fin.c1[i]}) + shift;
      if (pos > 34'sh0_7FFF_FFFF) begin
        res[i] = 32'h7FFF_FFFF;
      end else if (pos < -34'sh0_8000_0000) begin
        res[i] = 32'h8000_0000;
      end else begin
        res[i] = pos[31:0];
      end
      case (fin.sel)
        SEL_FIRST:  res[i] = fin.c1[i];
        SEL_SECOND: res[i] = fin.c2[i];
        default:    res[i] = res[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    merged_center_x <= res[0];
    merged_center_y <= res[1];
    merged_center_z <= res[2];
    merged_radius   <= fin.radius;
  end

  a_chain_dec : assert property (@(posedge clk) disable iff (rst)
    dec_valid |=> mul_valid)
    else $error("decision stage item lost before the product stage");

  a_merge_k : assert property (@(posedge clk) disable iff (rst)
    dec_valid && dec_tail.sel == SEL_MERGE |-> dec_k < dec_d)
    else $error("center shift factor not below the distance");

  a_zero_dist : assert property (@(posedge clk) disable iff (rst)
    dec_valid && dec_d == '0 |-> dec_tail.sel != SEL_MERGE)
    else $error("merge selected with coincident centers");

  a_first_radius : assert property (@(posedge clk) disable iff (rst)
    sv[SqrtSteps] && sel_next == SEL_FIRST |=> dec_tail.radius == $past(dr1))
    else $error("first sphere selected with a different radius");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounding sphere merge testbench
// Drives pairs of spheres into the merge block and predicts the enclosing
// sphere for each with exact wide arithmetic. Results are checked in order,
// covering containment both ways, coincident centers, extreme coordinates,
// radius saturation and random geometry under varying idle patterns.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        r;
  } sphere_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] first_center_x = '0;
  logic signed [31:0] first_center_y = '0;
  logic signed [31:0] first_center_z = '0;
  logic [30:0]        first_radius = '0;
  logic signed [31:0] second_center_x = '0;
  logic signed [31:0] second_center_y = '0;
  logic signed [31:0] second_center_z = '0;
  logic [30:0]        second_radius = '0;
  logic               done;
  logic signed [31:0] merged_center_x;
  logic signed [31:0] merged_center_y;
  logic signed [31:0] merged_center_z;
  logic [30:0]        merged_radius;

  sphere_t enclosing_q[$];
  int      errors = 0;
  int      merges_sent = 0;
  int      send_idle_pct = 0;

  always #10 clk = ~clk;

  bounding_sphere_merge_top DUT (.*);

  function automatic logic [33:0] int_sqrt(logic [65:0] s);
    logic [33:0] root;
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      logic [33:0] t;
      t = root | (34'd1 << b);
      if ({34'd0, t} * {34'd0, t} <= {2'd0, s}) root = t;
    end
    return root;
  endfunction

  function automatic sphere_t predict_enclosing(sphere_t a, sphere_t b);
    sphere_t res;
    logic signed [33:0] off[3];
    logic [65:0] sum;
    logic [35:0] d, r1, r2, newr, k;
    logic signed [63:0] ca[3];
    logic signed [63:0] cb[3];
    ca = '{a.cx, a.cy, a.cz};
    cb = '{b.cx, b.cy, b.cz};
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      logic [33:0] m;
      off[i] = cb[i] - ca[i];
      m = off[i] < 0 ? -off[i] : off[i];
      sum += {32'd0, m} * {32'd0, m};
    end
    d = int_sqrt(sum);
    r1 = a.r;
    r2 = b.r;
    if (r1 >= d + r2) return a;
    if (r2 >= d + r1) return b;
    newr = (d + r1 + r2) >> 1;
    k = newr - r1;
    for (int i = 0; i < 3; i++) begin
      logic [127:0] prod, q;
      logic signed [63:0] v;
      prod = {94'd0, (off[i] < 0 ? -off[i] : off[i])} * {92'd0, k};
      q = prod / {92'd0, d};
      v = ca[i] + (off[i] < 0 ? -$signed(q[63:0]) : $signed(q[63:0]));
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      ca[i] = v;
    end
    res.cx = ca[0][31:0];
    res.cy = ca[1][31:0];
    res.cz = ca[2][31:0];
    res.r = newr > 36'h7FFF_FFFF ? 31'h7FFF_FFFF : newr[30:0];
    return res;
  endfunction

  task automatic send_pair(sphere_t a, sphere_t b);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    first_center_x <= a.cx;
    first_center_y <= a.cy;
    first_center_z <= a.cz;
    first_radius <= a.r;
    second_center_x <= b.cx;
    second_center_y <= b.cy;
    second_center_z <= b.cz;
    second_radius <= b.r;
    @(posedge clk);
    while (busy) @(posedge clk);
    enclosing_q.push_back(predict_enclosing(a, b));
    merges_sent++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (enclosing_q.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        sphere_t e;
        e = enclosing_q.pop_front();
        if (merged_center_x !== e.cx) begin
          $error("merged_center_x exp %0d got %0d", e.cx, merged_center_x);
          errors++;
        end
        if (merged_center_y !== e.cy) begin
          $error("merged_center_y exp %0d got %0d", e.cy, merged_center_y);
          errors++;
        end
        if (merged_center_z !== e.cz) begin
          $error("merged_center_z exp %0d got %0d", e.cz, merged_center_z);
          errors++;
        end
        if (merged_radius !== e.r) begin
          $error("merged_radius exp %0d got %0d", e.r, merged_radius);
          errors++;
        end
      end
    end
  end

  function automatic sphere_t mk(int x, int y, int z, int r);
    sphere_t s;
    s.cx = x;
    s.cy = y;
    s.cz = z;
    s.r = r[30:0];
    return s;
  endfunction

  function automatic sphere_t rand_sphere(int mode);
    sphere_t s;
    case (mode)
      0: s = mk($urandom, $urandom, $urandom, $urandom);
      1: s = mk($urandom_range(2000000) - 1000000, $urandom_range(2000000) - 1000000,
                $urandom_range(2000000) - 1000000, $urandom_range(1500000));
      default: s = mk($urandom_range(64) - 32, $urandom_range(64) - 32,
                      $urandom_range(64) - 32, $urandom_range(100));
    endcase
    return s;
  endfunction

  task automatic drain();
    start <= 1'b0;
    while (enclosing_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    int mn, mx;
    mn = 32'h8000_0000;
    mx = 32'h7FFF_FFFF;
    send_pair(mk(0, 0, 0, 0), mk(0, 0, 0, 0));
    send_pair(mk(5, 5, 5, 10), mk(5, 5, 5, 10));
    send_pair(mk(5, 5, 5, 3), mk(5, 5, 5, 10));
    send_pair(mk(0, 0, 0, 100), mk(10, 0, 0, 90));
    send_pair(mk(0, 0, 0, 90), mk(10, 0, 0, 100));
    send_pair(mk(0, 0, 0, 1), mk(1000, -2000, 3000, 2));
    send_pair(mk(mn, mn, mn, 0), mk(mx, mx, mx, 0));
    send_pair(mk(mx, mx, mx, mx), mk(mn, mn, mn, mx));
    send_pair(mk(mn, mx, mn, mx), mk(mx, mn, mx, 0));
    send_pair(mk(0, 0, 0, mx), mk(0, 0, 0, mx));
    send_pair(mk(mn, 0, 0, mx), mk(mx, 0, 0, mx - 5));
    send_pair(mk(-1, -1, -1, 1), mk(1, 1, 1, 1));
    send_pair(mk(mx, mn, 0, 7), mk(mn, mx, 0, 7));
    send_pair(mk(32'h5555_5555, 32'hAAAA_AAAA, 0, 31'h2AAA_AAAA),
              mk(32'hAAAA_AAAA, 32'h5555_5555, 0, 31'h5555_5555));
    drain();
  endtask

  task automatic test_random(int count, int idle_pct);
    send_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      int mode;
      mode = $urandom_range(2);
      send_pair(rand_sphere(mode), rand_sphere(mode));
    end
    send_idle_pct = 0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(650, 17);
    drain();
    test_random(650, 62);
    test_random(650, 0);
    drain();
    repeat (100) @(posedge clk);
    $display("Merged %0d sphere pairs: directed extremes, containment, coincident", merges_sent);
    $display("centers and random spheres at three sender idle rates.");
    if (errors == 0 && enclosing_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
